// ===== sv/wsg_pkg.sv =====
package wsg_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 20;
  localparam logic [CfgIdxW-1:0] CFG_WAVE_TYPE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FREQUENCY = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_AMPLITUDE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DUTY      = 3'd4;

  localparam logic [1:0] WAVE_SINE     = 2'd0;
  localparam logic [1:0] WAVE_SQUARE   = 2'd1;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
  localparam logic [1:0] WAVE_SAW      = 2'd3;

  localparam logic [1:0] KIND_FIX = 2'd0;
  localparam logic [1:0] KIND_SIN = 2'd1;
  localparam logic [1:0] KIND_DIV = 2'd2;

  localparam logic [9:0] POINTS_FINE   = 10'd720;
  localparam logic [9:0] POINTS_MID    = 10'd144;
  localparam logic [9:0] POINTS_COARSE = 10'd72;

  localparam int unsigned QuarterLen = 180;
  localparam int unsigned DivStages  = 4;
  localparam int unsigned DivBits    = 3;

  typedef logic [30:0] sin_tab_t [0:QuarterLen];

  typedef struct packed {
    logic [10:0] rem;
    logic [11:0] nlow;
    logic [11:0] quo;
  } div_state_t;

  // shift and subtract quotient, only used while building the table
  function automatic longint unsigned cdiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q = {q[62:0], 1'b1};
      end else begin
        q = {q[62:0], 1'b0};
      end
    end
    return q;
  endfunction

  // quarter wave of sin(a*pi/360) in q30, taylor series to x^17
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t        tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    for (int a = 0; a <= QuarterLen; a++) begin
      x    = cdiv(longint'(a) * 64'd3373259426, 64'd360);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = cdiv((term * x2) >> 30, longint'((2 * n) * (2 * n + 1)));
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum > 64'sd1073741824) begin
        sum = 64'sd1073741824;
      end
      if (sum < 0) begin
        sum = 0;
      end
      tab[a] = sum[30:0];
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

// ===== sv/waveform_sample_generator.sv =====
// pipeline: 8 register stages from an accepted request to its result on the output
// throughput: one request per cycle, the whole pipeline holds under output stall
// division for triangle and saw runs as a 4-stage restoring divider, 3 bits a stage
// reset (async, active low) empties the pipeline and loads the default
// configuration: sine, 10000 Hz, amplitude 1241, offset 620, duty one half
module waveform_sample_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wsg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wsg_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [9:0]                    sample_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [11:0]                   sample_o,
  output logic                          index_valid_o,
  output logic                          period_end_o,
  output logic [9:0]                    period_points_o
);
  import wsg_pkg::*;

  logic [1:0]  wave_q;
  logic [19:0] freq_q;
  logic [11:0] amp_q;
  logic [11:0] ofs_q;
  logic [16:0] duty_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= WAVE_SINE;
      freq_q <= 20'd10000;
      amp_q  <= 12'd1241;
      ofs_q  <= 12'd620;
      duty_q <= 17'd32768;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WAVE_TYPE: wave_q <= cfg_data_i[1:0];
        CFG_FREQUENCY: freq_q <= cfg_data_i;
        CFG_AMPLITUDE: amp_q  <= cfg_data_i[11:0];
        CFG_OFFSET:    ofs_q  <= cfg_data_i[11:0];
        CFG_DUTY:      duty_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic en;
  logic [7:0] vld_q;
  assign en          = !vld_q[7] || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[7];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[6:0], in_valid_i};
    end
  end

  // stage 1: period, duty split, range flags
  logic [9:0]  pts;
  logic [16:0] dcl;
  logic [26:0] pd;
  logic [26:0] pd_rnd;
  logic [9:0]  rise0;
  logic [9:0]  rise;
  logic [9:0]  idx1_q, pts1_q, high1_q, rise1_q, fall1_q;
  logic        inr1_q, pend1_q;

  always_comb begin
    if (freq_q <= 20'd400) begin
      pts = POINTS_FINE;
    end else if (freq_q <= 20'd1250) begin
      pts = POINTS_MID;
    end else begin
      pts = POINTS_COARSE;
    end
    dcl    = (duty_q > 17'd65536) ? 17'd65536 : duty_q;
    pd     = 27'(pts) * 27'(dcl);
    pd_rnd = pd + 27'd32768;
    rise0  = pd_rnd[25:16];
    if (rise0 == 10'd0) begin
      rise = 10'd1;
    end else if (rise0 > pts) begin
      rise = pts;
    end else begin
      rise = rise0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx1_q  <= sample_index_i;
      pts1_q  <= pts;
      high1_q <= pd[25:16];
      rise1_q <= rise;
      fall1_q <= pts - rise;
      inr1_q  <= sample_index_i < pts;
      pend1_q <= sample_index_i == (pts - 10'd1);
    end
  end

  // stage 2: sine table lookup, divider operands
  logic [13:0] k;
  logic [9:0]  kr;
  logic [1:0]  quad;
  logic [9:0]  rr;
  logic [7:0]  ang;
  logic [1:0]  kind;
  logic [11:0] fixv;
  logic [10:0] m11;
  logic [9:0]  den;
  logic [10:0] two_i;
  logic [9:0]  sdiff;

  always_comb begin
    if (pts1_q == POINTS_FINE) begin
      k = 14'(idx1_q);
    end else if (pts1_q == POINTS_MID) begin
      k = 14'(idx1_q) * 14'd5;
    end else begin
      k = 14'(idx1_q) * 14'd10;
    end
    kr = inr1_q ? k[9:0] : 10'd0;
    if (kr >= 10'd540) begin
      quad = 2'd3;
      rr   = kr - 10'd540;
    end else if (kr >= 10'd360) begin
      quad = 2'd2;
      rr   = kr - 10'd360;
    end else if (kr >= 10'd180) begin
      quad = 2'd1;
      rr   = kr - 10'd180;
    end else begin
      quad = 2'd0;
      rr   = kr;
    end
    ang = quad[0] ? 8'(10'd180 - rr) : rr[7:0];

    kind  = KIND_FIX;
    fixv  = '0;
    m11   = '0;
    den   = 10'd1;
    two_i = {idx1_q, 1'b0};
    sdiff = fall1_q - 10'd1 - (idx1_q - rise1_q);
    case (wave_q)
      WAVE_SINE: begin
        kind = KIND_SIN;
      end
      WAVE_SQUARE: begin
        fixv = (idx1_q < high1_q) ? amp_q : 12'd0;
      end
      WAVE_TRIANGLE: begin
        kind = KIND_DIV;
        den  = pts1_q;
        m11  = (two_i < 11'(pts1_q)) ? two_i : {pts1_q - idx1_q, 1'b0};
      end
      WAVE_SAW: begin
        if (idx1_q < rise1_q) begin
          if (rise1_q == 10'd1) begin
            fixv = amp_q;
          end else begin
            kind = KIND_DIV;
            m11  = 11'(idx1_q);
            den  = rise1_q - 10'd1;
          end
        end else if (fall1_q <= 10'd1) begin
          fixv = '0;
        end else begin
          kind = KIND_DIV;
          m11  = 11'(sdiff);
          den  = fall1_q - 10'd1;
        end
      end
      default: ;
    endcase
  end

  logic [1:0]  kind2_q;
  logic [11:0] fix2_q;
  logic [9:0]  m2_q, den2_q;
  logic [30:0] sin2_q;
  logic        neg2_q;
  logic        inr2_q, pend2_q;
  logic [9:0]  pts2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind2_q <= kind;
      fix2_q  <= fixv;
      m2_q    <= m11[9:0];
      den2_q  <= den;
      sin2_q  <= SIN_TAB[ang];
      neg2_q  <= quad[1];
      inr2_q  <= inr1_q;
      pend2_q <= pend1_q;
      pts2_q  <= pts1_q;
    end
  end

  // stage 3: multiplies
  logic [31:0] sin_lvl;
  logic [21:0] am;
  assign sin_lvl = neg2_q ? (32'd1073741824 - 32'(sin2_q)) : (32'd1073741824 + 32'(sin2_q));
  assign am      = 22'(amp_q) * 22'(m2_q);

  logic [1:0]  kind3_q;
  logic [11:0] fix3_q;
  logic [22:0] num3_q;
  logic [10:0] dv3_q;
  logic [43:0] sp3_q;
  logic        inr3_q, pend3_q;
  logic [9:0]  pts3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind3_q <= kind2_q;
      fix3_q  <= fix2_q;
      num3_q  <= {am, 1'b0} + 23'(den2_q);
      dv3_q   <= {den2_q, 1'b0};
      sp3_q   <= 44'(amp_q) * 44'(sin_lvl);
      inr3_q  <= inr2_q;
      pend3_q <= pend2_q;
      pts3_q  <= pts2_q;
    end
  end

  // stages 4..7: divider, sine rounding in stage 4
  logic [43:0] sp_rnd;
  assign sp_rnd = sp3_q + 44'd1073741824;

  div_state_t div_in [DivStages];
  div_state_t div_out [DivStages];
  div_state_t div_q [DivStages];
  logic [10:0] dv_in [DivStages];
  logic [10:0] dv_q [DivStages];
  logic [1:0]  kind_q [DivStages];
  logic [12:0] aux_q [DivStages];
  logic        inr_q [DivStages];
  logic        pend_q [DivStages];
  logic [9:0]  ptsp_q [DivStages];

  assign div_in[0] = '{rem: num3_q[22:12], nlow: num3_q[11:0], quo: 12'd0};
  assign dv_in[0]  = dv3_q;

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    wsg_div_step u_step (
      .st_i      (div_in[g]),
      .divisor_i (dv_in[g]),
      .st_o      (div_out[g])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[g] <= div_out[g];
        dv_q[g]  <= dv_in[g];
      end
    end
    if (g == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (en) begin
          kind_q[g] <= kind3_q;
          aux_q[g]  <= (kind3_q == KIND_SIN) ? sp_rnd[43:31] : 13'(fix3_q);
          inr_q[g]  <= inr3_q;
          pend_q[g] <= pend3_q;
          ptsp_q[g] <= pts3_q;
        end
      end
    end else begin : g_chain
      assign div_in[g] = div_q[g-1];
      assign dv_in[g]  = dv_q[g-1];
      always_ff @(posedge clk_i) begin
        if (en) begin
          kind_q[g] <= kind_q[g-1];
          aux_q[g]  <= aux_q[g-1];
          inr_q[g]  <= inr_q[g-1];
          pend_q[g] <= pend_q[g-1];
          ptsp_q[g] <= ptsp_q[g-1];
        end
      end
    end
  end

  // stage 8: offset, saturation, output register
  logic [13:0] lvl;
  logic [13:0] tot;
  always_comb begin
    lvl = (kind_q[DivStages-1] == KIND_DIV) ? 14'(div_q[DivStages-1].quo)
                                             : 14'(aux_q[DivStages-1]);
    tot = lvl + 14'(ofs_q);
  end

  logic [11:0] sample_q;
  logic        ivld_q, pend_out_q;
  logic [9:0]  pts_out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sample_q   <= !inr_q[DivStages-1] ? 12'd0 :
                    (tot > 14'd4095) ? 12'd4095 : tot[11:0];
      ivld_q     <= inr_q[DivStages-1];
      pend_out_q <= inr_q[DivStages-1] && pend_q[DivStages-1];
      pts_out_q  <= ptsp_q[DivStages-1];
    end
  end

  assign sample_o        = sample_q;
  assign index_valid_o   = ivld_q;
  assign period_end_o    = pend_out_q;
  assign period_points_o = pts_out_q;

endmodule

// ===== sv/wsg_div_step.sv =====
module wsg_div_step (
  input  wsg_pkg::div_state_t st_i,
  input  logic [10:0]         divisor_i,
  output wsg_pkg::div_state_t st_o
);
  import wsg_pkg::*;

  logic [10:0] r;
  logic [11:0] nl;
  logic [11:0] qq;
  logic [11:0] t;
  logic [11:0] diff;

  always_comb begin
    r  = st_i.rem;
    nl = st_i.nlow;
    qq = st_i.quo;
    t  = '0;
    diff = '0;
    for (int j = 0; j < DivBits; j++) begin
      t    = {r, nl[11]};
      nl   = {nl[10:0], 1'b0};
      diff = t - {1'b0, divisor_i};
      if (t >= {1'b0, divisor_i}) begin
        r  = diff[10:0];
        qq = {qq[10:0], 1'b1};
      end else begin
        r  = t[10:0];
        qq = {qq[10:0], 1'b0};
      end
    end
    st_o.rem  = r;
    st_o.nlow = nl;
    st_o.quo  = qq;
  end

endmodule

// ===== sv/wsg_checker.sv =====
module wsg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] sample_o,
  input logic        index_valid_o,
  input logic        period_end_o,
  input logic [9:0]  period_points_o
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_o))
    else $error("stalled result changed");

  // out of range index gives zero
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !index_valid_o |-> sample_o == 12'd0 && !period_end_o)
    else $error("invalid index with nonzero sample");

  a_pts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> period_points_o == 10'd72 || period_points_o == 10'd144 ||
                    period_points_o == 10'd720)
    else $error("bad period length");

  // input back pressure only from a stalled full output
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

endmodule

bind waveform_sample_generator wsg_checker u_wsg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .sample_o        (sample_o),
  .index_valid_o   (index_valid_o),
  .period_end_o    (period_end_o),
  .period_points_o (period_points_o)
);
